[rtl/syrp_pkg.sv]
// Shared types and constants for the steering yaw-rate PID block.
// Holds register indexes, limits, controller states and the command/status bundles.
`default_nettype none

package syrp_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LATERAL_GAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CRUISE_SPEED = 3'd4;

    localparam int DIV_STEPS  = 24;
    localparam int DIV_CNT_W  = 5;
    localparam int CRUISE_MIN = 256;
    localparam int CRUISE_RST = 256;

    localparam int INTEG_LIMIT = 1200;
    localparam int OUT_LIMIT   = 144000;
    localparam int TURN_MAX    = 8388607;
    localparam int TURN_MIN    = -8388608;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL_SL,
        ST_MUL_TG,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_RET_D,
        ST_TOTAL,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        MUL_SCALE_LAT,
        MUL_TURN,
        MUL_PROP,
        MUL_INTEG,
        MUL_DERIV
    } mul_sel_t;

    typedef enum logic [2:0] {
        RET_NONE,
        RET_TURN,
        RET_PROP,
        RET_INTEG,
        RET_DERIV
    } ret_sel_t;

    typedef struct packed {
        logic     capture;
        logic     div_step;
        logic     mul_en;
        mul_sel_t mul_sel;
        ret_sel_t ret_sel;
        logic     integ_update;
        logic     prev_update;
        logic     acc_en;
        logic     total_en;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic div_last;
    } status_t;

endpackage

`default_nettype wire

[rtl/steering_yaw_rate_pid.sv]
// Steering yaw-rate PID top level: joins the sequencer and the datapath.
// Depends on syrp_pkg, syrp_ctrl and syrp_datapath.
//
// One request in gives one result out. Each accepted request is captured,
// run through the one-bit-per-cycle divider that forms speed_ratio, then
// through states in which a single shared 32x24 multiplier produces the turn
// target, P, I and D products in turn and the sum is clamped; the block is
// then ready for the next request, provided the result register is free.
// A finished result waits in its own output register, so the next request
// is taken while it waits; a result not yet taken by the time the following
// one finishes stalls the block. Configuration writes are always accepted
// and must only be issued while no request is in flight.
`default_nettype none

module steering_yaw_rate_pid (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [syrp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [syrp_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [15:0]                  lateral_error,
    input  logic        [15:0]                  speed_target,
    input  logic signed [15:0]                  yaw_rate,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic        [15:0]                  speed_ratio,
    output logic signed [23:0]                  turn_target,
    output logic signed [15:0]                  yaw_error,
    output logic signed [27:0]                  prop_term,
    output logic signed [28:0]                  deriv_term,
    output logic signed [18:0]                  turn_output
);
    import syrp_pkg::*;

    cmd_t    cmd;
    status_t stat;

    assign cfg_ready = 1'b1;

    syrp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    syrp_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .lateral_error (lateral_error),
        .speed_target  (speed_target),
        .yaw_rate      (yaw_rate),
        .speed_ratio   (speed_ratio),
        .turn_target   (turn_target),
        .yaw_error     (yaw_error),
        .prop_term     (prop_term),
        .deriv_term    (deriv_term),
        .turn_output   (turn_output)
    );

    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready
    ) else $error("request accepted while previous one still in flight");

    a_no_result_overwrite: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || out_ready)
    ) else $error("result register loaded while holding an untaken result");

    a_load_shows_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid
    ) else $error("loaded result not presented");

    a_output_clamped: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> ((turn_output <= 19'sd144000) && (turn_output >= -19'sd144000))
    ) else $error("turn output outside clamp range");

endmodule

`default_nettype wire

[rtl/syrp_ctrl.sv]
// Sequencer for the steering yaw-rate PID: walks the divider and the shared multiplier.
// Depends on syrp_pkg for states and the command/status bundles.
`default_nettype none

module syrp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  syrp_pkg::status_t stat,
    output syrp_pkg::cmd_t    cmd
);
    import syrp_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (stat.div_last)
                begin
                    state_next = ST_MUL_SL;
                end
            end
            ST_MUL_SL: state_next = ST_MUL_TG;
            ST_MUL_TG: state_next = ST_MUL_P;
            ST_MUL_P:  state_next = ST_MUL_I;
            ST_MUL_I:  state_next = ST_MUL_D;
            ST_MUL_D:  state_next = ST_RET_D;
            ST_RET_D:  state_next = ST_TOTAL;
            ST_TOTAL:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.mul_sel  = MUL_SCALE_LAT;
        cmd.ret_sel  = RET_NONE;
        in_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_MUL_SL:
            begin
                cmd.mul_en       = 1'b1;
                cmd.mul_sel      = MUL_SCALE_LAT;
                cmd.integ_update = 1'b1;
            end
            ST_MUL_TG:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_TURN;
            end
            ST_MUL_P:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_PROP;
                cmd.ret_sel = RET_TURN;
            end
            ST_MUL_I:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_INTEG;
                cmd.ret_sel = RET_PROP;
            end
            ST_MUL_D:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DERIV;
                cmd.ret_sel = RET_INTEG;
            end
            ST_RET_D:
            begin
                cmd.ret_sel     = RET_DERIV;
                cmd.acc_en      = 1'b1;
                cmd.prev_update = 1'b1;
            end
            ST_TOTAL:
            begin
                cmd.total_en = 1'b1;
            end
            ST_OUT:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[rtl/syrp_datapath.sv]
// Datapath for the steering yaw-rate PID: config registers, radix-2 divider,
// shared 32x24 multiplier, PID state and result registers. Depends on syrp_pkg.
`default_nettype none

module syrp_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  syrp_pkg::cmd_t                      cmd,
    output syrp_pkg::status_t                   stat,
    input  logic                                cfg_we,
    input  logic [syrp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [syrp_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic signed [15:0]                  lateral_error,
    input  logic        [15:0]                  speed_target,
    input  logic signed [15:0]                  yaw_rate,
    output logic        [15:0]                  speed_ratio,
    output logic signed [23:0]                  turn_target,
    output logic signed [15:0]                  yaw_error,
    output logic signed [27:0]                  prop_term,
    output logic signed [28:0]                  deriv_term,
    output logic signed [18:0]                  turn_output
);
    import syrp_pkg::*;

    logic signed [15:0] prop_gain_reg;
    logic signed [15:0] integ_gain_reg;
    logic signed [15:0] deriv_gain_reg;
    logic signed [23:0] lateral_gain_reg;
    logic        [15:0] cruise_speed_reg;

    logic signed [15:0] lat_reg;
    logic signed [15:0] err_reg;
    logic        [15:0] rem_reg;
    logic        [23:0] quo_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic signed [55:0] prod_reg;
    logic signed [23:0] turn_reg;
    logic signed [27:0] p_reg;
    logic signed [23:0] i_reg;
    logic signed [28:0] d_reg;
    logic signed [29:0] acc_reg;
    logic signed [18:0] total_reg;
    logic signed [11:0] integ_reg;
    logic signed [15:0] prev_reg;

    logic        [15:0] divisor;
    logic        [16:0] rem_shift;
    logic        [17:0] rem_diff;
    logic               q_bit;
    logic signed [15:0] err_in;
    logic signed [16:0] integ_sum;
    logic signed [11:0] integ_next;
    logic signed [16:0] diff;
    logic signed [31:0] mul_a;
    logic signed [23:0] mul_b;
    logic signed [55:0] mul_p;
    logic signed [55:0] bias;
    logic signed [55:0] rnd;
    logic signed [31:0] turn_q;
    logic signed [23:0] turn_sat;
    logic signed [30:0] total_sum;
    logic signed [18:0] total_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg    <= '0;
            integ_gain_reg   <= '0;
            deriv_gain_reg   <= '0;
            lateral_gain_reg <= '0;
            cruise_speed_reg <= 16'(CRUISE_RST);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PROP_GAIN:    prop_gain_reg    <= cfg_data[15:0];
                CFG_INTEG_GAIN:   integ_gain_reg   <= cfg_data[15:0];
                CFG_DERIV_GAIN:   deriv_gain_reg   <= cfg_data[15:0];
                CFG_LATERAL_GAIN: lateral_gain_reg <= cfg_data;
                CFG_CRUISE_SPEED: cruise_speed_reg <= cfg_data[15:0];
                default:          prop_gain_reg    <= prop_gain_reg;
            endcase
        end
    end

    assign divisor   = (cruise_speed_reg < 16'(CRUISE_MIN)) ? 16'(CRUISE_MIN)
                                                             : cruise_speed_reg;
    assign rem_shift = {rem_reg, quo_reg[23]};
    assign rem_diff  = {1'b0, rem_shift} - {2'b00, divisor};
    assign q_bit     = !rem_diff[17];

    assign stat.div_last = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

    assign err_in = (yaw_rate == 16'sh8000) ? 16'sh7FFF : -yaw_rate;

    assign integ_sum = 17'(err_reg) + 17'(integ_reg);
    always_comb
    begin
        priority if (integ_sum > 17'(INTEG_LIMIT))
        begin
            integ_next = 12'(INTEG_LIMIT);
        end
        else if (integ_sum < 17'(-INTEG_LIMIT))
        begin
            integ_next = 12'(-INTEG_LIMIT);
        end
        else
        begin
            integ_next = integ_sum[11:0];
        end
    end

    assign diff = 17'(err_reg) - 17'(prev_reg);

    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_SCALE_LAT:
            begin
                mul_a = 32'(lat_reg);
                mul_b = {8'h00, quo_reg[15:0]};
            end
            MUL_TURN:
            begin
                mul_a = prod_reg[31:0];
                mul_b = lateral_gain_reg;
            end
            MUL_PROP:
            begin
                mul_a = 32'(err_reg);
                mul_b = 24'(prop_gain_reg);
            end
            MUL_INTEG:
            begin
                mul_a = 32'(integ_reg);
                mul_b = 24'(integ_gain_reg);
            end
            MUL_DERIV:
            begin
                mul_a = 32'(diff);
                mul_b = 24'(deriv_gain_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        bias = '0;
        if (prod_reg[55])
        begin
            bias = (cmd.ret_sel == RET_TURN) ? 56'sh00_0000_00FF_FFFF : 56'sd15;
        end
    end

    assign rnd    = prod_reg + bias;
    assign turn_q = rnd[55:24];

    always_comb
    begin
        priority if (turn_q > 32'(TURN_MAX))
        begin
            turn_sat = 24'(TURN_MAX);
        end
        else if (turn_q < 32'(TURN_MIN))
        begin
            turn_sat = 24'(TURN_MIN);
        end
        else
        begin
            turn_sat = turn_q[23:0];
        end
    end

    assign total_sum = 31'(acc_reg) + 31'(d_reg);
    always_comb
    begin
        priority if (total_sum > 31'(OUT_LIMIT))
        begin
            total_sat = 19'(OUT_LIMIT);
        end
        else if (total_sum < 31'(-OUT_LIMIT))
        begin
            total_sat = 19'(-OUT_LIMIT);
        end
        else
        begin
            total_sat = total_sum[18:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= '0;
            prev_reg  <= '0;
        end
        else
        begin
            if (cmd.integ_update)
            begin
                integ_reg <= integ_next;
            end
            if (cmd.prev_update)
            begin
                prev_reg <= err_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            lat_reg <= lateral_error;
            err_reg <= err_in;
            rem_reg <= '0;
            quo_reg <= {speed_target, 8'h00};
        end
        else if (cmd.div_step)
        begin
            rem_reg <= q_bit ? rem_diff[15:0] : rem_shift[15:0];
            quo_reg <= {quo_reg[22:0], q_bit};
        end
        if (cmd.mul_en)
        begin
            prod_reg <= mul_p;
        end
        unique case (cmd.ret_sel)
            RET_TURN:  turn_reg <= turn_sat;
            RET_PROP:  p_reg    <= rnd[31:4];
            RET_INTEG: i_reg    <= rnd[27:4];
            RET_DERIV: d_reg    <= rnd[32:4];
            default:   turn_reg <= turn_reg;
        endcase
        if (cmd.acc_en)
        begin
            acc_reg <= 30'(turn_reg) + 30'(p_reg) + 30'(i_reg);
        end
        if (cmd.total_en)
        begin
            total_reg <= total_sat;
        end
        if (cmd.out_load)
        begin
            speed_ratio <= quo_reg[15:0];
            turn_target <= turn_reg;
            yaw_error   <= err_reg;
            prop_term   <= p_reg;
            deriv_term  <= d_reg;
            turn_output <= total_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.capture)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
    end

endmodule

`default_nettype wire
